// ----- rtl/core/gtl_pkg.sv -----
// shared types, constants and register map for the global to local index block
// no dependencies
`timescale 1ns / 1ps
package gtl_pkg;

  localparam int NUM_GRIDS_DEF = 2;
  localparam int GRID_W        = 1;
  localparam int DIM_W         = 16;
  localparam int IDX_W         = 48;
  localparam int REG_INDEX_W   = 3;
  localparam int COMP_W        = 2;

  // register map
  localparam logic [REG_INDEX_W-1:0] REG_GRIDS_IN_USE = 3'd0;
  localparam logic [REG_INDEX_W-1:0] REG_G0_GDIMS     = 3'd1;
  localparam logic [REG_INDEX_W-1:0] REG_G0_LOFFSET   = 3'd2;
  localparam logic [REG_INDEX_W-1:0] REG_G0_LDIMS     = 3'd3;
  localparam logic [REG_INDEX_W-1:0] REG_G1_GDIMS     = 3'd4;
  localparam logic [REG_INDEX_W-1:0] REG_G1_LOFFSET   = 3'd5;
  localparam logic [REG_INDEX_W-1:0] REG_G1_LDIMS     = 3'd6;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BEYOND    = 2'd1;
  localparam logic [1:0] ST_NOT_LOCAL = 2'd2;

  // per item tags that ride along the divider chain
  typedef struct packed {
    logic [GRID_W-1:0] grid;
    logic              bad;
    logic [COMP_W-1:0] comp;
    logic [DIM_W-1:0]  ir;
  } side_t;

  localparam int SIDE_W = $bits(side_t);

endpackage

// ----- rtl/core/global_to_local_param_index.sv -----
// top level: config registers, front search, divider chain, back composition
// uses gtl_pkg, gtl_front, gtl_div, gtl_back
`timescale 1ns / 1ps
// Translates a global material parameter index (three values per grid point,
// grids laid end to end) into the index within the local active box.
// Channels: the s_ group takes one 48-bit global index per beat; the m_ group
// returns the local index in m_tdata and a status in m_tuser (0 ok, 1 index
// beyond all grids, 2 point outside the local box; m_tdata is 0 unless ok).
// The cfg port writes registers by index: 0 grids in use, 1..3 grid 0
// global dims, local offset, local dims, 4..6 the same for grid 1. Write
// config only while no beat is in flight; cfg_ready is always high.
// From input beat to result the pipeline holds 5 stages for grid sizes
// and search, 3 stages for /3 (one 16-bit digit per stage by reciprocal
// multiply), 80 divider stages (48 for /ni, 32 for /nj, one quotient bit
// per stage) and 4 stages for box check and composition.
// One beat is taken every cycle while the sink keeps up.
// When the receiver stalls a held result, the whole pipeline freezes and
// s_tready drops; nothing is lost or repeated.
// Reset empties the pipeline, sets grids in use to 1 and clears all dims.
module global_to_local_param_index #(
  parameter int NUM_GRIDS = gtl_pkg::NUM_GRIDS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gtl_pkg::REG_INDEX_W-1:0] cfg_index,
  input  logic [gtl_pkg::IDX_W-1:0]       cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [gtl_pkg::IDX_W-1:0]       s_tdata,   // [47:0] global_index
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [gtl_pkg::IDX_W-1:0]       m_tdata,   // [47:0] local_param_index
  output logic [1:0]                      m_tuser    // [1:0] status
);
  import gtl_pkg::*;

  // reciprocal of 3 for an 18-bit partial dividend, exact below 2**19
  localparam logic [DIM_W+1:0] RECIP3    = 18'h2AAAB;
  localparam int               RECIP3_SH = 19;

  logic [1:0]       grids_in_use;
  logic [IDX_W-1:0] gdims   [NUM_GRIDS];
  logic [IDX_W-1:0] loffset [NUM_GRIDS];
  logic [IDX_W-1:0] ldims   [NUM_GRIDS];

  // register decode
  logic              wr_gu, wr_gd, wr_lo, wr_ld;
  logic [GRID_W-1:0] wr_grid;

  always_comb begin
    wr_gu   = 1'b0;
    wr_gd   = 1'b0;
    wr_lo   = 1'b0;
    wr_ld   = 1'b0;
    wr_grid = '0;
    unique case (cfg_index)
      REG_GRIDS_IN_USE: wr_gu = 1'b1;
      REG_G0_GDIMS:     wr_gd = 1'b1;
      REG_G0_LOFFSET:   wr_lo = 1'b1;
      REG_G0_LDIMS:     wr_ld = 1'b1;
      REG_G1_GDIMS: begin
        wr_gd   = 1'b1;
        wr_grid = 1'b1;
      end
      REG_G1_LOFFSET: begin
        wr_lo   = 1'b1;
        wr_grid = 1'b1;
      end
      REG_G1_LDIMS: begin
        wr_ld   = 1'b1;
        wr_grid = 1'b1;
      end
      default: ;
    endcase
  end

  assign cfg_ready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grids_in_use <= 2'd1;
      for (int g = 0; g < NUM_GRIDS; g++) begin
        gdims[g]   <= '0;
        loffset[g] <= '0;
        ldims[g]   <= '0;
      end
    end else if (cfg_valid) begin
      if (wr_gu) grids_in_use <= cfg_data[1:0];
      for (int g = 0; g < NUM_GRIDS; g++) begin
        if (wr_grid == GRID_W'(g)) begin
          if (wr_gd) gdims[g]   <= cfg_data;
          if (wr_lo) loffset[g] <= cfg_data;
          if (wr_ld) ldims[g]   <= cfg_data;
        end
      end
    end
  end

  // whole pipeline advances when the output register is free
  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // grid search
  logic             f_valid;
  logic [IDX_W-1:0] f_rel;
  side_t            f_side;

  gtl_front #(.NUM_GRIDS(NUM_GRIDS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .in_valid     (s_tvalid),
    .in_index     (s_tdata),
    .grids_in_use (grids_in_use),
    .gdims        (gdims),
    .out_valid    (f_valid),
    .out_rel      (f_rel),
    .out_side     (f_side)
  );

  // one 16-bit digit of long division by 3: returns quotient digit and remainder
  function automatic logic [DIM_W+COMP_W-1:0] div3_step(
    input logic [COMP_W-1:0] rin,
    input logic [DIM_W-1:0]  dig
  );
    logic [DIM_W+1:0]   t;
    logic [2*DIM_W+3:0] pr;
    logic [DIM_W-1:0]   q;
    logic [DIM_W+1:0]   rr;
    t  = {rin, dig};
    pr = t * RECIP3;
    q  = pr[RECIP3_SH+DIM_W-1:RECIP3_SH];
    rr = t - {1'b0, q, 1'b0} - {2'b00, q};
    return {q, rr[COMP_W-1:0]};
  endfunction

  // split off the component: rel / 3, high digit first
  logic                      d3_v1, d3_v2, c_valid;
  logic [DIM_W+COMP_W-1:0]   div_a, div_b, div_c;
  logic [DIM_W-1:0]          d3_q1;
  logic [2*DIM_W-1:0]        d3_q2;
  logic [COMP_W-1:0]         d3_r1, d3_r2, c_comp;
  logic [2*DIM_W-1:0]        d3_lo1;
  logic [DIM_W-1:0]          d3_lo2;
  side_t                     d3_s1, d3_s2;
  logic [IDX_W-1:0]          c_quot;
  side_t                     c_side, i_side_in;

  assign div_a = div3_step('0, f_rel[3*DIM_W-1:2*DIM_W]);
  assign div_b = div3_step(d3_r1, d3_lo1[2*DIM_W-1:DIM_W]);
  assign div_c = div3_step(d3_r2, d3_lo2);

  always_ff @(posedge clk) begin
    if (rst) begin
      d3_v1   <= 1'b0;
      d3_v2   <= 1'b0;
      c_valid <= 1'b0;
    end else if (adv) begin
      d3_v1   <= f_valid;
      d3_v2   <= d3_v1;
      c_valid <= d3_v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d3_q1  <= div_a[DIM_W+COMP_W-1:COMP_W];
      d3_r1  <= div_a[COMP_W-1:0];
      d3_lo1 <= f_rel[2*DIM_W-1:0];
      d3_s1  <= f_side;

      d3_q2  <= {d3_q1, div_b[DIM_W+COMP_W-1:COMP_W]};
      d3_r2  <= div_b[COMP_W-1:0];
      d3_lo2 <= d3_lo1[DIM_W-1:0];
      d3_s2  <= d3_s1;

      c_quot <= {d3_q2, div_c[DIM_W+COMP_W-1:COMP_W]};
      c_comp <= div_c[COMP_W-1:0];
      c_side <= d3_s2;
    end
  end

  always_comb begin
    i_side_in      = c_side;
    i_side_in.comp = c_comp;
  end

  // point / ni gives i and the rest
  logic              i_valid;
  logic [IDX_W-1:0]  i_quot;
  logic [DIM_W-1:0]  i_rem;
  logic [SIDE_W-1:0] i_side_raw;
  side_t             i_side, j_side_in;

  gtl_div #(.W(IDX_W), .SW(SIDE_W)) u_divi (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .in_valid    (c_valid),
    .in_dividend (c_quot),
    .in_divisor  (gdims[c_side.grid][DIM_W-1:0]),
    .in_side     (i_side_in),
    .out_valid   (i_valid),
    .out_quot    (i_quot),
    .out_rem     (i_rem),
    .out_side    (i_side_raw)
  );

  assign i_side = side_t'(i_side_raw);

  always_comb begin
    j_side_in    = i_side;
    j_side_in.ir = i_rem;
  end

  // rest / nj gives j and k
  logic               j_valid;
  logic [2*DIM_W-1:0] j_quot;
  logic [DIM_W-1:0]   j_rem;
  logic [SIDE_W-1:0]  j_side_raw;

  gtl_div #(.W(2*DIM_W), .SW(SIDE_W)) u_divj (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .in_valid    (i_valid),
    .in_dividend (i_quot[2*DIM_W-1:0]),
    .in_divisor  (gdims[i_side.grid][2*DIM_W-1:DIM_W]),
    .in_side     (j_side_in),
    .out_valid   (j_valid),
    .out_quot    (j_quot),
    .out_rem     (j_rem),
    .out_side    (j_side_raw)
  );

  // local box check and output register
  gtl_back #(.NUM_GRIDS(NUM_GRIDS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_valid   (j_valid),
    .in_side    (side_t'(j_side_raw)),
    .jr         (j_rem),
    .kr         (j_quot[DIM_W-1:0]),
    .loffset    (loffset),
    .ldims      (ldims),
    .out_valid  (m_tvalid),
    .out_index  (m_tdata),
    .out_status (m_tuser)
  );

  // a failed lookup never carries an index
  a_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_OK |-> m_tdata == '0)
    else $error("nonzero index with error status");

  // status is always one of the defined codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_BEYOND || m_tuser == ST_NOT_LOCAL))
    else $error("undefined status code");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result present right after reset");

endmodule

// ----- rtl/core/gtl_div.sv -----
// pipelined restoring divider, one quotient bit per stage, 16-bit divisor
// uses gtl_pkg for the divisor width
`timescale 1ns / 1ps
module gtl_div #(
  parameter int W  = 48,
  parameter int SW = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic                      in_valid,
  input  logic [W-1:0]              in_dividend,
  input  logic [gtl_pkg::DIM_W-1:0] in_divisor,
  input  logic [SW-1:0]             in_side,
  output logic                      out_valid,
  output logic [W-1:0]              out_quot,
  output logic [gtl_pkg::DIM_W-1:0] out_rem,
  output logic [SW-1:0]             out_side
);
  import gtl_pkg::*;

  logic [DIM_W-1:0] rem  [W];
  logic [DIM_W-1:0] dvs  [W];
  logic [W-1:0]     nq   [W];
  logic [SW-1:0]    side [W];
  logic             vld  [W];

  for (genvar s = 0; s < W; s++) begin : g_stage
    logic [DIM_W-1:0] rem_i;
    logic [DIM_W-1:0] d_i;
    logic [W-1:0]     nq_i;
    logic [SW-1:0]    side_i;
    logic             v_i;
    logic [DIM_W:0]   trial;
    logic [DIM_W:0]   diff;
    logic             ge;

    if (s == 0) begin : g_first
      assign rem_i  = '0;
      assign d_i    = in_divisor;
      assign nq_i   = in_dividend;
      assign side_i = in_side;
      assign v_i    = in_valid;
    end else begin : g_next
      assign rem_i  = rem[s-1];
      assign d_i    = dvs[s-1];
      assign nq_i   = nq[s-1];
      assign side_i = side[s-1];
      assign v_i    = vld[s-1];
    end

    // trial subtract of the next dividend bit
    assign trial = {rem_i, nq_i[W-1]};
    assign diff  = trial - {1'b0, d_i};
    assign ge    = (trial >= {1'b0, d_i});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (adv) begin
        vld[s] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[s]  <= ge ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
        nq[s]   <= {nq_i[W-2:0], ge};
        dvs[s]  <= d_i;
        side[s] <= side_i;
      end
    end
  end

  assign out_valid = vld[W-1];
  assign out_quot  = nq[W-1];
  assign out_rem   = rem[W-1];
  assign out_side  = side[W-1];

endmodule

// ----- rtl/core/gtl_front.sv -----
// front stages: grid sizes from the global dims and the grid search
// uses gtl_pkg for widths and the side_t tag
`timescale 1ns / 1ps
module gtl_front #(
  parameter int NUM_GRIDS = gtl_pkg::NUM_GRIDS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic                      in_valid,
  input  logic [gtl_pkg::IDX_W-1:0] in_index,
  input  logic [1:0]                grids_in_use,
  input  logic [gtl_pkg::IDX_W-1:0] gdims [NUM_GRIDS],
  output logic                      out_valid,
  output logic [gtl_pkg::IDX_W-1:0] out_rel,
  output gtl_pkg::side_t            out_side
);
  import gtl_pkg::*;

  logic             v1, v2, v3, v4;
  logic [IDX_W-1:0] gidx1, gidx2, gidx3, gidx4;
  logic [2*DIM_W-1:0] pij  [NUM_GRIDS];
  logic [IDX_W-1:0]   pijk [NUM_GRIDS];
  logic [IDX_W+1:0]   size3 [NUM_GRIDS];

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  // grid sizes: ni*nj, then *nk, then *3
  always_ff @(posedge clk) begin
    if (adv) begin
      gidx1 <= in_index;
      gidx2 <= gidx1;
      gidx3 <= gidx2;
      gidx4 <= gidx3;
      for (int g = 0; g < NUM_GRIDS; g++) begin
        pij[g]   <= gdims[g][DIM_W-1:0] * gdims[g][2*DIM_W-1:DIM_W];
        pijk[g]  <= pij[g] * gdims[g][3*DIM_W-1:2*DIM_W];
        size3[g] <= {1'b0, pijk[g], 1'b0} + {2'b00, pijk[g]};
      end
    end
  end

  // search for the grid whose half-open range holds the index
  logic [1:0]        ngrids;
  logic [IDX_W+2:0]  start;
  logic [IDX_W+2:0]  idx_ext;
  logic              found;
  logic [GRID_W-1:0] sel;
  logic [IDX_W-1:0]  relv;

  assign ngrids  = (grids_in_use > 2'(NUM_GRIDS)) ? 2'(NUM_GRIDS) : grids_in_use;
  assign idx_ext = {3'b000, gidx4};

  always_comb begin
    start = '0;
    found = 1'b0;
    sel   = '0;
    relv  = '0;
    for (int g = 0; g < NUM_GRIDS; g++) begin
      if (2'(g) < ngrids && !found && idx_ext >= start &&
          (idx_ext - start) < {1'b0, size3[g]}) begin
        found = 1'b1;
        sel   = GRID_W'(g);
        relv  = IDX_W'(idx_ext - start);
      end
      start = start + {1'b0, size3[g]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_rel  <= relv;
      out_side <= '{grid: sel, bad: !found, comp: '0, ir: '0};
    end
  end

endmodule

// ----- rtl/core/gtl_back.sv -----
// back stages: local box check and local index composition, output register
// uses gtl_pkg for widths, status codes and the side_t tag
`timescale 1ns / 1ps
module gtl_back #(
  parameter int NUM_GRIDS = gtl_pkg::NUM_GRIDS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic                      in_valid,
  input  gtl_pkg::side_t            in_side,
  input  logic [gtl_pkg::DIM_W-1:0] jr,
  input  logic [gtl_pkg::DIM_W-1:0] kr,
  input  logic [gtl_pkg::IDX_W-1:0] loffset [NUM_GRIDS],
  input  logic [gtl_pkg::IDX_W-1:0] ldims   [NUM_GRIDS],
  output logic                      out_valid,
  output logic [gtl_pkg::IDX_W-1:0] out_index,
  output logic [1:0]                out_status
);
  import gtl_pkg::*;

  logic [DIM_W-1:0] ir, oi, oj, ok, ni, nj, nk;
  logic [DIM_W-1:0] li, lj, lk;
  logic             inbox;

  assign ir = in_side.ir;
  assign oi = loffset[in_side.grid][DIM_W-1:0];
  assign oj = loffset[in_side.grid][2*DIM_W-1:DIM_W];
  assign ok = loffset[in_side.grid][3*DIM_W-1:2*DIM_W];
  assign ni = ldims[in_side.grid][DIM_W-1:0];
  assign nj = ldims[in_side.grid][2*DIM_W-1:DIM_W];
  assign nk = ldims[in_side.grid][3*DIM_W-1:2*DIM_W];
  assign li = ir - oi;
  assign lj = jr - oj;
  assign lk = kr - ok;
  assign inbox = ir >= oi && li < ni && jr >= oj && lj < nj && kr >= ok && lk < nk;

  logic              v1, v2, v3;
  logic              bad1, bad2, bad3, in1, in2, in3;
  logic [GRID_W-1:0] grid1, grid2;
  logic [COMP_W-1:0] comp1, comp2, comp3;
  logic [DIM_W-1:0]  li1, li2, li3, lj1, lj2, lk1;
  logic [2*DIM_W-1:0] t1;
  logic [IDX_W-1:0]   t2;
  logic [2*DIM_W:0]   lsum;
  logic [IDX_W:0]     prod;
  logic [IDX_W-1:0]   x;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  // box check, then nj*lk, then ni*(lj + nj*lk), then 3*(.. + li) + component
  assign lsum = {1'b0, t1} + {{(DIM_W+1){1'b0}}, lj2};
  assign prod = lsum * ldims[grid2][DIM_W-1:0];
  assign x    = t2 + {{(IDX_W-DIM_W){1'b0}}, li3};

  always_ff @(posedge clk) begin
    if (adv) begin
      bad1  <= in_side.bad;
      in1   <= inbox;
      grid1 <= in_side.grid;
      comp1 <= in_side.comp;
      li1   <= li;
      lj1   <= lj;
      lk1   <= lk;

      bad2  <= bad1;
      in2   <= in1;
      grid2 <= grid1;
      comp2 <= comp1;
      li2   <= li1;
      lj2   <= lj1;
      t1    <= ldims[grid1][2*DIM_W-1:DIM_W] * lk1;

      bad3  <= bad2;
      in3   <= in2;
      comp3 <= comp2;
      li3   <= li2;
      t2    <= prod[IDX_W-1:0];

      if (bad3) begin
        out_status <= ST_BEYOND;
        out_index  <= '0;
      end else if (!in3) begin
        out_status <= ST_NOT_LOCAL;
        out_index  <= '0;
      end else begin
        out_status <= ST_OK;
        out_index  <= {x[IDX_W-2:0], 1'b0} + x + {{(IDX_W-COMP_W){1'b0}}, comp3};
      end
    end
  end

endmodule
